// ----- sv/fhc_pkg.sv -----
// ----------------------------------------------------------------------------
// fhc_pkg
// Shared types and constants of the frame header checker: header layout,
// magic bytes, status codes, register map and the result record.
// ----------------------------------------------------------------------------
package fhc_pkg;

  // Byte counter width and its saturation value.
  localparam int unsigned COUNT_W = 33;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Header layout, in byte positions within the buffer.
  localparam logic [COUNT_W-1:0] POS_VERSION  = 33'd4;
  localparam logic [COUNT_W-1:0] POS_FLAGS    = 33'd6;
  localparam logic [COUNT_W-1:0] POS_SEQUENCE = 33'd8;
  localparam logic [COUNT_W-1:0] POS_SIZE     = 33'd16;
  localparam logic [COUNT_W-1:0] HDR_LEN      = 33'd20;

  // Magic "YAL1", indexed by byte position.
  localparam logic [7:0] MAGIC [4] = '{8'h59, 8'h41, 8'h4C, 8'h31};

  // Configuration port.
  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_MAX_PAYLOAD      = 2'd0;
  localparam logic [1:0] REG_EXPECTED_VERSION = 2'd1;
  localparam logic [1:0] REG_ALLOWED_FLAGS    = 2'd2;

  localparam logic [31:0] MAX_PAYLOAD_RST      = 32'd65536;
  localparam logic [15:0] EXPECTED_VERSION_RST = 16'd1;
  localparam logic [15:0] ALLOWED_FLAGS_RST    = 16'd1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_MAGIC     = 3'd2,
    ST_VERSION   = 3'd3,
    ST_FLAGS     = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_TOO_LARGE = 3'd6,
    ST_LENGTH    = 3'd7
  } fhc_status_t;

  typedef struct packed {
    logic [31:0] max_payload;
    logic [15:0] expected_version;
    logic [15:0] allowed_flags;
  } fhc_cfg_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        done_res;
    fhc_status_t status;
    logic [15:0] hdr_version;
    logic [15:0] hdr_flags;
    logic [63:0] hdr_sequence;
    logic [31:0] hdr_payload_size;
  } fhc_result_t;

endpackage

// ----- sv/fhc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// fhc_cfg_regs
// APB-style register file holding the three checker limits.
// ----------------------------------------------------------------------------
module fhc_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fhc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output fhc_pkg::fhc_cfg_t          cfg
);

  fhc_pkg::fhc_cfg_t regs;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.max_payload      <= fhc_pkg::MAX_PAYLOAD_RST;
      regs.expected_version <= fhc_pkg::EXPECTED_VERSION_RST;
      regs.allowed_flags    <= fhc_pkg::ALLOWED_FLAGS_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        fhc_pkg::REG_MAX_PAYLOAD:      regs.max_payload      <= pwdata;
        fhc_pkg::REG_EXPECTED_VERSION: regs.expected_version <= pwdata[15:0];
        fhc_pkg::REG_ALLOWED_FLAGS:    regs.allowed_flags    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      fhc_pkg::REG_MAX_PAYLOAD:      prdata = regs.max_payload;
      fhc_pkg::REG_EXPECTED_VERSION: prdata = {16'd0, regs.expected_version};
      fhc_pkg::REG_ALLOWED_FLAGS:    prdata = {16'd0, regs.allowed_flags};
      default:                       prdata = 32'd0;
    endcase
  end

endmodule

// ----- sv/fhc_parser.sv -----
// ----------------------------------------------------------------------------
// fhc_parser
// Per-buffer state: byte counter, magic check and header field shifters.
// Produces the result record for the byte being transferred.
// ----------------------------------------------------------------------------
module fhc_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            in_byte,
  input  logic                  end_of_buffer,
  input  fhc_pkg::fhc_cfg_t     cfg,
  output logic                  res_valid,
  output fhc_pkg::fhc_result_t  res
);

  logic [fhc_pkg::COUNT_W-1:0] byte_count;
  logic                        magic_match;
  logic [15:0]                 version_reg;
  logic [15:0]                 flags_reg;
  logic [63:0]                 sequence_reg;
  logic [31:0]                 size_reg;

  logic [fhc_pkg::COUNT_W-1:0] byte_count_next;
  logic                        magic_match_next;
  logic [15:0]                 version_next;
  logic [15:0]                 flags_next;
  logic [63:0]                 sequence_next;
  logic [31:0]                 size_next;
  logic [fhc_pkg::COUNT_W-1:0] expected_total;
  logic                        is_payload;
  fhc_pkg::fhc_status_t        st;

  // Field capture: each header byte shifts into the field it belongs to.
  always_comb begin
    magic_match_next = magic_match;
    version_next     = version_reg;
    flags_next       = flags_reg;
    sequence_next    = sequence_reg;
    size_next        = size_reg;
    if (byte_count < fhc_pkg::POS_VERSION) begin
      if (in_byte != fhc_pkg::MAGIC[byte_count[1:0]]) magic_match_next = 1'b0;
    end else if (byte_count < fhc_pkg::POS_FLAGS) begin
      version_next = {version_reg[7:0], in_byte};
    end else if (byte_count < fhc_pkg::POS_SEQUENCE) begin
      flags_next = {flags_reg[7:0], in_byte};
    end else if (byte_count < fhc_pkg::POS_SIZE) begin
      sequence_next = {sequence_reg[55:0], in_byte};
    end else if (byte_count < fhc_pkg::HDR_LEN) begin
      size_next = {size_reg[23:0], in_byte};
    end
    byte_count_next = (byte_count == fhc_pkg::COUNT_MAX) ? byte_count
                                                         : byte_count + 1'b1;
  end

  assign is_payload     = byte_count >= fhc_pkg::HDR_LEN;
  assign res_valid      = is_payload || end_of_buffer;
  assign expected_total = {1'b0, size_next} + fhc_pkg::HDR_LEN;

  // Status checks in priority order, using the state including this byte.
  always_comb begin
    if (byte_count_next < fhc_pkg::HDR_LEN) begin
      st = fhc_pkg::ST_SHORT;
    end else if (!magic_match_next) begin
      st = fhc_pkg::ST_MAGIC;
    end else if (version_next != cfg.expected_version) begin
      st = fhc_pkg::ST_VERSION;
    end else if ((flags_next & ~cfg.allowed_flags) != 16'd0) begin
      st = fhc_pkg::ST_FLAGS;
    end else if (size_next == 32'd0) begin
      st = fhc_pkg::ST_EMPTY;
    end else if (size_next > cfg.max_payload) begin
      st = fhc_pkg::ST_TOO_LARGE;
    end else if (byte_count_next != expected_total) begin
      st = fhc_pkg::ST_LENGTH;
    end else begin
      st = fhc_pkg::ST_OK;
    end
  end

  always_comb begin
    res.payload_valid    = is_payload;
    res.payload_byte     = is_payload ? in_byte : 8'd0;
    res.done_res         = end_of_buffer;
    res.status           = fhc_pkg::ST_OK;
    res.hdr_version      = 16'd0;
    res.hdr_flags        = 16'd0;
    res.hdr_sequence     = 64'd0;
    res.hdr_payload_size = 32'd0;
    if (end_of_buffer) begin
      res.status = st;
      // The header is reported only once it was complete and the magic held.
      if (st != fhc_pkg::ST_SHORT && st != fhc_pkg::ST_MAGIC) begin
        res.hdr_version      = version_next;
        res.hdr_flags        = flags_next;
        res.hdr_sequence     = sequence_next;
        res.hdr_payload_size = size_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_buffer)) begin
      byte_count   <= '0;
      magic_match  <= 1'b1;
      version_reg  <= '0;
      flags_reg    <= '0;
      sequence_reg <= '0;
      size_reg     <= '0;
    end else if (accept) begin
      byte_count   <= byte_count_next;
      magic_match  <= magic_match_next;
      version_reg  <= version_next;
      flags_reg    <= flags_next;
      sequence_reg <= sequence_next;
      size_reg     <= size_next;
    end
  end

endmodule

// ----- sv/fhc_out_skid.sv -----
// ----------------------------------------------------------------------------
// fhc_out_skid
// Two-entry output buffer: a result register plus a skid register, so the
// input side is ready from a register and never waits on the output ready.
// ----------------------------------------------------------------------------
module fhc_out_skid (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  fhc_pkg::fhc_result_t  push_data,
  output logic                  ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fhc_pkg::fhc_result_t  out_data
);

  fhc_pkg::fhc_result_t skid_data;
  logic                 skid_valid;
  logic                 pop;

  assign ready = !skid_valid;
  assign pop   = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) out_data <= skid_data;
    end else if (push) begin
      if (!out_valid || pop) out_data <= push_data;
      else skid_data <= push_data;
    end
  end

endmodule

// ----- sv/frame_header_checker.sv -----
// ----------------------------------------------------------------------------
// frame_header_checker
// Byte-stream frame checker: verifies the magic, unpacks the 20-byte header,
// forwards payload bytes and reports a status on the last byte of a buffer.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle on the input channel whenever in_ready
// is high: the per-byte work is a counter increment, a shift of one
// header field and the status compare, all between the parser state registers
// and a two-entry output buffer. Header bytets 0 to 19 produce no output
// transfer unless they end the buffer; every byte from position 20 on
// produces one output transfer carrying payload_byte, and the byte flagged
// with end_of_buffer produces one transfer carrying done_res, status and the
// decoded header (a payload byte and the final status can share one
// transfer). Each result is registered in the output slot or the skid slot.
// in_ready drops only when both output slots hold results that the
// consumer has not taken yet, and it comes from a register, so there is no
// combinational path from out_ready to in_ready. Status codes follow the
// priority short buffer, bad magic, wrong version, unknown flags, empty
// payload, payload too large, length mismatch; the byte counter saturates at
// 2^33-1. Limits are written over the APB-style port at byte addresses 0x0
// (max_payload), 0x4 (expected_version) and 0x8 (allowed_flags), and should
// only be changed while no buffer is in flight.
// ----------------------------------------------------------------------------
module frame_header_checker (
  input  logic                       clk,
  input  logic                       rst,
  // Input byte channel.
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_byte,
  input  logic                       end_of_buffer,
  // Result channel.
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       payload_valid,
  output logic [7:0]                 payload_byte,
  output logic                       done_res,
  output logic [2:0]                 status,
  output logic [15:0]                hdr_version,
  output logic [15:0]                hdr_flags,
  output logic [63:0]                hdr_sequence,
  output logic [31:0]                hdr_payload_size,
  // Configuration port.
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fhc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  fhc_pkg::fhc_cfg_t    cfg;
  fhc_pkg::fhc_result_t res;
  fhc_pkg::fhc_result_t out_res;
  logic                 res_valid;
  logic                 accept;

  // An input transfer completes whenever the skid slot is free; bytes that
  // yield no result are consumed the same way as those that do.
  assign accept = in_valid && in_ready;

  fhc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fhc_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .in_byte       (in_byte),
    .end_of_buffer (end_of_buffer),
    .cfg           (cfg),
    .res_valid     (res_valid),
    .res           (res)
  );

  fhc_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_valid),
    .push_data (res),
    .ready     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign payload_valid    = out_res.payload_valid;
  assign payload_byte     = out_res.payload_byte;
  assign done_res         = out_res.done_res;
  assign status           = out_res.status;
  assign hdr_version      = out_res.hdr_version;
  assign hdr_flags        = out_res.hdr_flags;
  assign hdr_sequence     = out_res.hdr_sequence;
  assign hdr_payload_size = out_res.hdr_payload_size;

endmodule

// ----- test/tb_frame_header_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frame_header_checker
// Self-checking bench for the frame header checker. Buffers of bytes are
// sent over the input channel. A bit-accurate predictor tracks the header
// parse and queues one expected result for every payload byte and for every
// byte that ends a buffer. The output channel is compared field by field.
// Both channels see random idle bursts, and the limit registers are moved
// through several settings, the extremes among them, between phases.
// ----------------------------------------------------------------------------
module tb_frame_header_checker;

  // Cycles with no transfer on any channel before the run is declared hung.
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  // Cycles to let pass once the last expected result has been seen.
  localparam int unsigned DRAIN_CYCLES   = 8;
  // Random input bytes sent under each register setting.
  localparam int unsigned PHASE_ITEMS    = 180;

  // Kinds of random buffer. Close to half are well formed, so that the parse gets
  // all the way to the payload, and the rest break one header check each.
  typedef enum int unsigned {
    FK_GOOD, FK_MAGIC, FK_VERSION, FK_FLAGS, FK_EMPTY,
    FK_TOO_LARGE, FK_LENGTH, FK_SHORT, FK_NOISE
  } frame_kind_t;

  // One row of the directed table. When typed_res is set, the row carries
  // its own expected result instead of the predictor's.
  typedef struct {
    logic [7:0]           data;
    logic                 last;
    bit                   typed_res;
    fhc_pkg::fhc_result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        end_of_buffer;

  logic        out_valid;
  logic        out_ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic        done_res;
  logic [2:0]  status;
  logic [15:0] hdr_version;
  logic [15:0] hdr_flags;
  logic [63:0] hdr_sequence;
  logic [31:0] hdr_payload_size;

  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [fhc_pkg::ADDR_W-1:0] paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;

  // Register values as the bench believes the block holds them.
  logic [31:0] cfg_max_payload;
  logic [15:0] cfg_version;
  logic [15:0] cfg_flags;

  // Parse state of the buffer in flight, as the predictor sees it.
  logic [fhc_pkg::COUNT_W-1:0] fr_count;
  logic                        fr_magic_ok;
  logic [15:0]                 fr_version;
  logic [15:0]                 fr_flags;
  logic [63:0]                 fr_sequence;
  logic [31:0]                 fr_size;

  fhc_pkg::fhc_result_t pending_results [$];
  stim_row_t            dir_rows [$];

  int unsigned mismatches      = 0;
  int unsigned items_sent      = 0;
  int unsigned buffers_sent    = 0;
  int unsigned results_checked = 0;
  int unsigned settings_used   = 1;
  int unsigned idle_cycles     = 0;
  logic [7:0]  status_seen     = '0;

  // Idling controls, changed per buffer by the stimulus process.
  bit src_idle_en  = 1'b1;
  bit sink_stall_en = 1'b1;

  frame_header_checker u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .end_of_buffer    (end_of_buffer),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .payload_valid    (payload_valid),
    .payload_byte     (payload_byte),
    .done_res         (done_res),
    .status           (status),
    .hdr_version      (hdr_version),
    .hdr_flags        (hdr_flags),
    .hdr_sequence     (hdr_sequence),
    .hdr_payload_size (hdr_payload_size),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Returns the parse to its empty state, ready for the next buffer.
  function automatic void clear_frame_state();
    fr_count    = '0;
    fr_magic_ok = 1'b1;
    fr_version  = '0;
    fr_flags    = '0;
    fr_sequence = '0;
    fr_size     = '0;
  endfunction

  // Advances the parse by one accepted byte. has_res tells whether the byte
  // produces an output transfer: it does when it lies in the payload or
  // ends the buffer.
  function automatic fhc_pkg::fhc_result_t frame_byte_result(input logic [7:0] b,
                                                             input logic last,
                                                             output bit has_res);
    fhc_pkg::fhc_result_t        r;
    logic [fhc_pkg::COUNT_W-1:0] pos;
    bit                          in_payload;
    pos        = fr_count;
    in_payload = (pos >= fhc_pkg::HDR_LEN);
    // Each header byte shifts into the field that its position belongs to;
    // all fields are big-endian.
    if (pos < fhc_pkg::POS_VERSION) begin
      if (b != fhc_pkg::MAGIC[pos[1:0]]) fr_magic_ok = 1'b0;
    end else if (pos < fhc_pkg::POS_FLAGS) begin
      fr_version = {fr_version[7:0], b};
    end else if (pos < fhc_pkg::POS_SEQUENCE) begin
      fr_flags = {fr_flags[7:0], b};
    end else if (pos < fhc_pkg::POS_SIZE) begin
      fr_sequence = {fr_sequence[55:0], b};
    end else if (pos < fhc_pkg::HDR_LEN) begin
      fr_size = {fr_size[23:0], b};
    end
    fr_count = (pos < fhc_pkg::COUNT_MAX) ? pos + 1'b1 : fhc_pkg::COUNT_MAX;

    has_res         = in_payload || last;
    r               = '0;
    r.payload_valid = in_payload;
    r.payload_byte  = in_payload ? b : 8'h00;
    r.done_res      = last;
    if (last) begin
      // The decoded header is reported only once the buffer was long enough
      // and the magic matched; the remaining checks go in priority order.
      if (fr_count < fhc_pkg::HDR_LEN) begin
        r.status = fhc_pkg::ST_SHORT;
      end else if (!fr_magic_ok) begin
        r.status = fhc_pkg::ST_MAGIC;
      end else begin
        if (fr_version != cfg_version) r.status = fhc_pkg::ST_VERSION;
        else if ((fr_flags & ~cfg_flags) != '0) r.status = fhc_pkg::ST_FLAGS;
        else if (fr_size == '0) r.status = fhc_pkg::ST_EMPTY;
        else if (fr_size > cfg_max_payload) r.status = fhc_pkg::ST_TOO_LARGE;
        else if (fr_count != fhc_pkg::HDR_LEN + {1'b0, fr_size})
          r.status = fhc_pkg::ST_LENGTH;
        else r.status = fhc_pkg::ST_OK;
        r.hdr_version      = fr_version;
        r.hdr_flags        = fr_flags;
        r.hdr_sequence     = fr_sequence;
        r.hdr_payload_size = fr_size;
      end
      clear_frame_state();
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offers one byte on the input channel and waits for its transfer. The
  // task is entered and left at a rising edge, so the next call can drive a
  // new byte at once and keep in_valid high between back-to-back bytes.
  task automatic send_byte(input logic [7:0] b, input logic last, input bit typed_res,
                           input fhc_pkg::fhc_result_t typed);
    fhc_pkg::fhc_result_t r;
    bit                   has_res;
    if (src_idle_en && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte       <= b;
    end_of_buffer <= last;
    do @(posedge clk); while (!in_ready);
    // The transfer happened at this edge; predict what it must produce.
    r = frame_byte_result(b, last, has_res);
    if (has_res) pending_results.push_back(typed_res ? typed : r);
    items_sent++;
    if (last) buffers_sent++;
  endtask

  // Builds one random buffer of the given kind and sends it. Payloads stay
  // short so that many buffers, and many final statuses, fit in the run.
  task automatic send_frame(input frame_kind_t kind);
    logic [7:0]           hdr [20];
    logic [7:0]           data;
    logic [15:0]          ver;
    logic [15:0]          flg;
    logic [63:0]          seq;
    logic [31:0]          size;
    logic [31:0]          cap;
    int unsigned          pay_len;
    int unsigned          len;
    int unsigned          k;
    int unsigned          i;
    fhc_pkg::fhc_result_t unused;
    unused = '0;
    ver    = cfg_version;
    flg    = 16'($urandom) & cfg_flags;
    seq    = {$urandom, $urandom};
    cap    = (cfg_max_payload < 32'd24) ? cfg_max_payload : 32'd24;
    // With a zero limit no size can pass; such a buffer ends too large.
    size    = (cap == '0) ? 32'd1 : 32'($urandom_range(cap, 1));
    pay_len = size;
    for (i = 0; i < 4; i++) hdr[i] = fhc_pkg::MAGIC[i];

    case (kind)
      FK_MAGIC: begin
        k      = $urandom_range(0, 3);
        hdr[k] = hdr[k] ^ (8'h01 << $urandom_range(0, 7));
      end
      FK_VERSION: ver = cfg_version ^ 16'($urandom_range(1, 65535));
      FK_FLAGS: begin
        // Set one flag bit that the mask does not permit, if there is one.
        if (cfg_flags != 16'hFFFF) begin
          do k = $urandom_range(0, 15); while (cfg_flags[k]);
          flg[k] = 1'b1;
        end
      end
      FK_EMPTY: begin
        size    = '0;
        pay_len = $urandom_range(0, 6);
      end
      FK_TOO_LARGE: begin
        if (cfg_max_payload != 32'hFFFF_FFFF)
          size = $urandom_range(32'hFFFF_FFFF, cfg_max_payload + 1);
        pay_len = $urandom_range(0, 8);
      end
      FK_LENGTH: begin
        pay_len = $urandom_range(0, 30);
        if (pay_len == size) pay_len++;
      end
      default: ;
    endcase

    hdr[4] = ver[15:8];
    hdr[5] = ver[7:0];
    hdr[6] = flg[15:8];
    hdr[7] = flg[7:0];
    for (i = 0; i < 8; i++) hdr[8 + i] = seq[63 - 8*i -: 8];
    for (i = 0; i < 4; i++) hdr[16 + i] = size[31 - 8*i -: 8];

    len = 20 + pay_len;
    if (kind == FK_SHORT) len = $urandom_range(1, 19);
    if (kind == FK_NOISE) len = $urandom_range(1, 40);
    for (i = 0; i < len; i++) begin
      data = (kind != FK_NOISE && i < 20) ? hdr[i] : 8'($urandom);
      send_byte(data, (i == len - 1), 1'b0, unused);
    end
  endtask

  // Picks a kind of buffer: close to half are well formed.
  function automatic frame_kind_t pick_kind();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return FK_GOOD;
    if (roll < 52) return FK_MAGIC;
    if (roll < 59) return FK_VERSION;
    if (roll < 66) return FK_FLAGS;
    if (roll < 73) return FK_EMPTY;
    if (roll < 80) return FK_TOO_LARGE;
    if (roll < 88) return FK_LENGTH;
    if (roll < 95) return FK_SHORT;
    return FK_NOISE;
  endfunction

  // Sends random buffers until about n bytes have gone out. Idling is
  // chosen per buffer so that some buffers run with no gaps at all.
  task automatic run_frames(input int unsigned n, input bit quiet);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < n) begin
      src_idle_en   = !quiet && ($urandom_range(0, 3) != 0);
      sink_stall_en = !quiet && ($urandom_range(0, 3) != 0);
      send_frame(pick_kind());
    end
  endtask

  // Lowers in_valid and waits until every queued result has come out. No
  // result is left to come, but a header byte may still be in the pipeline,
  // so the extra cycles given pass before the block counts as idle.
  task automatic wait_idle(input int unsigned extra);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // One register write over the configuration port: a setup phase, then an
  // access phase that completes at the edge where pready is high.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      fhc_pkg::REG_MAX_PAYLOAD:      cfg_max_payload = value;
      fhc_pkg::REG_EXPECTED_VERSION: cfg_version     = value[15:0];
      fhc_pkg::REG_ALLOWED_FLAGS:    cfg_flags       = value[15:0];
      default: ;
    endcase
  endtask

  // Moves all three limits to a new setting once the block is idle.
  task automatic apply_limits(input logic [31:0] max_pay, input logic [15:0] ver,
                              input logic [15:0] flg);
    wait_idle(4);
    write_reg(fhc_pkg::REG_MAX_PAYLOAD, max_pay);
    write_reg(fhc_pkg::REG_EXPECTED_VERSION, {16'h0000, ver});
    write_reg(fhc_pkg::REG_ALLOWED_FLAGS, {16'h0000, flg});
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // out_ready is held low in random bursts while stalling is enabled, and
  // returns high between any two bursts.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_stall_en && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Every output transfer is compared with the oldest expected result.
  always @(posedge clk) begin
    fhc_pkg::fhc_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d byte %0h",
                 $time, status, payload_byte);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("payload_valid", 64'(want.payload_valid), 64'(payload_valid));
        check_field("payload_byte", 64'(want.payload_byte), 64'(payload_byte));
        check_field("done_res", 64'(want.done_res), 64'(done_res));
        check_field("status", 64'(want.status), 64'(status));
        check_field("hdr_version", 64'(want.hdr_version), 64'(hdr_version));
        check_field("hdr_flags", 64'(want.hdr_flags), 64'(hdr_flags));
        check_field("hdr_sequence", want.hdr_sequence, hdr_sequence);
        check_field("hdr_payload_size", 64'(want.hdr_payload_size),
                    64'(hdr_payload_size));
        if (want.done_res) status_seen[want.status] = 1'b1;
        results_checked++;
      end
    end
  end

  // Watchdog: any transfer, or a register access, shows progress. A long
  // run of cycles without one means the block has hung.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    fhc_pkg::fhc_result_t short_res;
    fhc_pkg::fhc_result_t ok_res;
    fhc_pkg::fhc_result_t none;
    logic [7:0]           hdr_bytes [20];
    int unsigned          i;

    rst           = 1'b1;
    in_valid      = 1'b0;
    in_byte       = '0;
    end_of_buffer = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;

    cfg_max_payload = fhc_pkg::MAX_PAYLOAD_RST;
    cfg_version     = fhc_pkg::EXPECTED_VERSION_RST;
    cfg_flags       = fhc_pkg::ALLOWED_FLAGS_RST;
    clear_frame_state();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table. A one-byte buffer of either extreme value ends short
    // with an all-zero header. A minimal good frame under the reset limits
    // follows: version 1, flags 1, an all-ones sequence and a one-byte
    // payload of 0xFF that also carries the final status.
    none                = '0;
    short_res           = '0;
    short_res.done_res  = 1'b1;
    short_res.status    = fhc_pkg::ST_SHORT;
    ok_res                  = '0;
    ok_res.payload_valid    = 1'b1;
    ok_res.payload_byte     = 8'hFF;
    ok_res.done_res         = 1'b1;
    ok_res.status           = fhc_pkg::ST_OK;
    ok_res.hdr_version      = 16'h0001;
    ok_res.hdr_flags        = 16'h0001;
    ok_res.hdr_sequence     = 64'hFFFF_FFFF_FFFF_FFFF;
    ok_res.hdr_payload_size = 32'd1;
    hdr_bytes = '{8'h59, 8'h41, 8'h4C, 8'h31, 8'h00, 8'h01, 8'h00, 8'h01,
                  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  8'h00, 8'h00, 8'h00, 8'h01};

    dir_rows.push_back('{data: 8'h00, last: 1'b1, typed_res: 1'b1, res: short_res});
    dir_rows.push_back('{data: 8'hFF, last: 1'b1, typed_res: 1'b1, res: short_res});
    for (i = 0; i < 20; i++)
      dir_rows.push_back('{data: hdr_bytes[i], last: 1'b0, typed_res: 1'b0, res: none});
    dir_rows.push_back('{data: 8'hFF, last: 1'b1, typed_res: 1'b1, res: ok_res});

    foreach (dir_rows[i])
      send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed_res, dir_rows[i].res);

    // Random buffers under the reset limits, then under both extremes,
    // then under random limits. The last phase runs with no idling.
    run_frames(PHASE_ITEMS, 1'b0);
    apply_limits(32'h0000_0000, 16'hFFFF, 16'hFFFF);
    run_frames(PHASE_ITEMS, 1'b0);
    apply_limits(32'hFFFF_FFFF, 16'h0000, 16'h0000);
    run_frames(PHASE_ITEMS, 1'b0);
    apply_limits(32'($urandom_range(1, 30)), 16'($urandom), 16'($urandom));
    run_frames(PHASE_ITEMS, 1'b0);
    apply_limits($urandom, 16'($urandom_range(0, 3)), 16'($urandom));
    src_idle_en   = 1'b0;
    sink_stall_en = 1'b0;
    run_frames(PHASE_ITEMS, 1'b1);

    wait_idle(DRAIN_CYCLES);

    $display("sent %0d bytes in %0d buffers under %0d limit settings",
             items_sent, buffers_sent, settings_used);
    $display("compared %0d results; final status codes seen (bit per code): %b",
             results_checked, status_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/fhc_pkg.sv
sv/fhc_cfg_regs.sv
sv/fhc_parser.sv
sv/fhc_out_skid.sv
sv/frame_header_checker.sv
test/tb_frame_header_checker.sv
